// ----- rtl/ypc_pkg.sv -----
// shared constants, codes and helper functions of the camera view block
// no dependencies
`timescale 1ns / 1ps

package ypc_pkg;

    // fixed formats
    localparam int VEC_FRAC = 14;
    localparam int VEC_W    = 16;
    localparam int POS_W    = 32;
    localparam int ANG_W    = 25;
    localparam int MUL_BITS = 32;
    localparam int DIV_BITS = 64;
    localparam int SQRT_STEPS = 32;

    localparam int TRIG_ITERATIONS_DEF = 16;
    localparam int ATAN_ENTRIES = 24;

    // angles in degrees, unsigned Q9.16
    localparam int DEG_FULL    = 360 * 65536;
    localparam int DEG_HALF    = 180 * 65536;
    localparam int DEG_QUARTER = 90 * 65536;

    localparam logic signed [31:0] CORDIC_K = 32'sh26DD3B6A;
    localparam logic signed [63:0] VEC_ONE  = 64'sd1 <<< VEC_FRAC;

    // reset values of the settings
    localparam logic [15:0] MOVE_GAIN_RST   = 16'd655;
    localparam logic [15:0] ROTATE_GAIN_RST = 16'd6554;

    // event kinds
    localparam logic [1:0] REQ_MOVE   = 2'd0;
    localparam logic [1:0] REQ_ROTATE = 2'd1;
    localparam logic [1:0] REQ_ZOOM   = 2'd2;

    // register indexes
    localparam logic [2:0] CFG_MOVE_GAIN   = 3'd0;
    localparam logic [2:0] CFG_ROTATE_GAIN = 3'd1;
    localparam logic [2:0] CFG_START_X     = 3'd2;
    localparam logic [2:0] CFG_START_Y     = 3'd3;
    localparam logic [2:0] CFG_START_Z     = 3'd4;

    // view matrix rows
    localparam logic [1:0] ROW_RIGHT = 2'd0;
    localparam logic [1:0] ROW_UP    = 2'd1;
    localparam logic [1:0] ROW_FWD   = 2'd2;

    typedef logic signed [VEC_W-1:0] t_vec;

    // arctangent of 2^-i in degrees Q7.16
    function automatic logic [22:0] ypc_atan(input logic [4:0] idx);
        logic [22:0] v;
        case (idx)
            5'd0:    v = 23'd2949120;
            5'd1:    v = 23'd1740967;
            5'd2:    v = 23'd919879;
            5'd3:    v = 23'd466945;
            5'd4:    v = 23'd234379;
            5'd5:    v = 23'd117304;
            5'd6:    v = 23'd58666;
            5'd7:    v = 23'd29335;
            5'd8:    v = 23'd14668;
            5'd9:    v = 23'd7334;
            5'd10:   v = 23'd3667;
            5'd11:   v = 23'd1833;
            5'd12:   v = 23'd917;
            5'd13:   v = 23'd458;
            5'd14:   v = 23'd229;
            5'd15:   v = 23'd115;
            5'd16:   v = 23'd57;
            5'd17:   v = 23'd29;
            5'd18:   v = 23'd14;
            5'd19:   v = 23'd7;
            5'd20:   v = 23'd4;
            5'd21:   v = 23'd2;
            5'd22:   v = 23'd1;
            default: v = 23'd0;
        endcase
        return v;
    endfunction

    // clamp to [-1.0, +1.0] in vector format
    function automatic t_vec clamp_vec(input logic signed [63:0] v);
        t_vec r;
        if (v > VEC_ONE) begin
            r = VEC_W'(VEC_ONE);
        end else if (v < -VEC_ONE) begin
            r = VEC_W'(-VEC_ONE);
        end else begin
            r = v[VEC_W-1:0];
        end
        return r;
    endfunction

    // saturate to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/yaw_pitch_camera_view_update.sv -----
// one event at a time: the input stalls from acceptance until the last row has been
// registered for output; every step runs on the shared serial multiplier, divider, square
// root or cordic unit, and an output stall holds the block in the emit state
// the last row sits in the output register while the next event is taken
// synchronous active-low reset loads the default gains, position zero, yaw 90 degrees
`timescale 1ns / 1ps

module yaw_pitch_camera_view_update import ypc_pkg::*; #(
    parameter int TRIG_ITERATIONS = TRIG_ITERATIONS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // event input
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [1:0]              i_req_type,
    input  logic signed [31:0]      i_operand_a,
    input  logic signed [31:0]      i_operand_b,
    // matrix rows out
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [1:0]              o_row_index,
    output logic signed [VEC_W-1:0] o_coef_x,
    output logic signed [VEC_W-1:0] o_coef_y,
    output logic signed [VEC_W-1:0] o_coef_z,
    output logic signed [31:0]      o_translation,
    output logic                    o_degenerate,
    output logic                    o_last,
    // settings write
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [2:0]              i_cfg_index,
    input  logic [31:0]             i_cfg_data
);

    localparam int FWD_SHIFT  = 60 - VEC_FRAC;
    localparam int SIN_SHIFT  = 30 - VEC_FRAC;
    localparam int NORM_SHIFT = 58 - 2 * VEC_FRAC;

    typedef enum logic [3:0] {
        S_IDLE, S_GAIN_A, S_GAIN_B, S_WRAP, S_TRIG, S_FWD, S_SQ, S_SQRT,
        S_DIV, S_CROSS, S_NORM_END, S_MOVE_UP, S_MOVE_RGT, S_ZOOM, S_ROW_MUL, S_EMIT
    } t_state;

    t_state r_state;
    logic   r_issued;     // unit launched for the current step
    logic [1:0] r_k;      // component / step index
    logic [1:0] r_row;
    logic   r_pass;       // 0 normalising right, 1 normalising up
    logic   r_degen;
    logic [1:0] r_kind;
    logic signed [31:0] r_opa;
    logic signed [31:0] r_opb;
    logic [15:0] r_move_gain;
    logic [15:0] r_rot_gain;

    // camera state
    logic signed [31:0] r_pos [3];
    logic [ANG_W-1:0]   r_yaw;
    logic [ANG_W-1:0]   r_pitch;
    t_vec r_fwd [3];
    t_vec r_rgt [3];
    t_vec r_up  [3];

    // working registers
    t_vec r_nf [3];               // new forward
    t_vec r_nr [3];               // new right
    t_vec r_no [3];               // normaliser output
    logic signed [17:0] r_nv [3]; // vector being normalised
    logic signed [31:0] r_lat;
    logic signed [31:0] r_ver;
    logic signed [35:0] r_t1;
    logic signed [33:0] r_wsum;
    logic signed [31:0] r_sy;
    logic signed [31:0] r_cy;
    logic signed [31:0] r_sp;
    logic signed [31:0] r_cp;
    logic signed [63:0] r_acc;
    logic [31:0]        r_len;

    // output register
    logic               r_out_valid;
    logic [1:0]         r_out_row;
    t_vec               r_out_cx;
    t_vec               r_out_cy;
    t_vec               r_out_cz;
    logic signed [31:0] r_out_trans;
    logic               r_out_degen;
    logic               r_out_last;

    // unit handshakes
    logic mul_go, div_go, sqrt_go, trig_go;
    logic mul_done, div_done, sqrt_done, trig_done;
    logic signed [MUL_BITS:0]   mcand;
    logic signed [MUL_BITS-1:0] mplier;
    logic signed [63:0]         prod;
    logic [DIV_BITS-1:0]        dvd;
    logic [31:0]                dsr;
    logic [DIV_BITS-1:0]        quot;
    logic [31:0]                drem;
    logic [63:0]                radicand;
    logic [31:0]                root;
    logic [ANG_W-1:0]           trig_angle;
    logic signed [31:0]         trig_sin;
    logic signed [31:0]         trig_cos;

    // helpers
    logic [15:0]        gain;
    logic signed [31:0] p16;
    logic signed [63:0] p14;
    logic signed [63:0] sq_val;
    logic [33:0]        wsum_abs;
    logic [ANG_W-1:0]   wrapped;
    logic [17:0]        nv_abs;
    logic signed [63:0] qsigned;
    t_vec               row_vec [3];
    logic               in_acc;
    logic               out_free;

    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;

    always_comb begin
        gain     = (r_kind == REQ_MOVE) ? r_move_gain : r_rot_gain;
        p16      = 32'((prod + 64'sd32768) >>> 16);
        p14      = (prod + 64'sd8192) >>> VEC_FRAC;
        sq_val   = (64'(r_sp) + (64'sd1 <<< (SIN_SHIFT - 1))) >>> SIN_SHIFT;
        wsum_abs = r_wsum[33] ? 34'(-r_wsum) : 34'(r_wsum);
        if (r_wsum[33] && drem != 32'd0) begin
            wrapped = ANG_W'(32'(DEG_FULL) - drem);
        end else begin
            wrapped = ANG_W'(drem);
        end
        nv_abs  = r_nv[r_k][17] ? 18'(-r_nv[r_k]) : 18'(r_nv[r_k]);
        qsigned = r_nv[r_k][17] ? -$signed(quot) : $signed(quot);
        // row 2 of the view matrix is the negated forward vector
        for (int i = 0; i < 3; i++) begin
            case (r_row)
                ROW_RIGHT: row_vec[i] = r_rgt[i];
                ROW_UP:    row_vec[i] = r_up[i];
                default:   row_vec[i] = VEC_W'(-r_fwd[i]);
            endcase
        end
    end

    // operand selection for the shared units
    always_comb begin
        mul_go     = 1'b0;
        div_go     = 1'b0;
        sqrt_go    = 1'b0;
        trig_go    = 1'b0;
        mcand      = '0;
        mplier     = '0;
        dvd        = '0;
        dsr        = '0;
        radicand   = '0;
        trig_angle = r_k[0] ? r_pitch : r_yaw;
        case (r_state)
            S_GAIN_A: begin
                mul_go = 1'b1;
                mcand  = {17'b0, gain};
                mplier = r_opa;
            end
            S_GAIN_B: begin
                mul_go = 1'b1;
                mcand  = {17'b0, gain};
                mplier = r_opb;
            end
            S_WRAP: begin
                div_go = 1'b1;
                dvd    = {30'b0, wsum_abs};
                dsr    = 32'(DEG_FULL);
            end
            S_TRIG: begin
                trig_go = 1'b1;
            end
            S_FWD: begin
                mul_go = 1'b1;
                mcand  = r_k[0] ? 33'(r_sy) : 33'(r_cy);
                mplier = r_cp;
            end
            S_SQ: begin
                mul_go = 1'b1;
                mcand  = 33'(r_nv[r_k]);
                mplier = 32'(r_nv[r_k]);
            end
            S_SQRT: begin
                sqrt_go  = 1'b1;
                radicand = 64'(r_acc) << NORM_SHIFT;
            end
            S_DIV: begin
                div_go = 1'b1;
                dvd    = (64'(nv_abs) << 29) + 64'(r_len >> 1);
                dsr    = r_len;
            end
            S_CROSS: begin
                mul_go = 1'b1;
                case (r_k)
                    2'd0: begin
                        mcand  = 33'(r_nr[2]);
                        mplier = 32'(r_nf[1]);
                    end
                    2'd1: begin
                        mcand  = 33'(r_nr[2]);
                        mplier = 32'(r_nf[0]);
                    end
                    2'd2: begin
                        mcand  = 33'(r_nr[0]);
                        mplier = 32'(r_nf[2]);
                    end
                    default: begin
                        mcand  = 33'(r_nr[0]);
                        mplier = 32'(r_nf[1]);
                    end
                endcase
            end
            S_MOVE_UP: begin
                mul_go = 1'b1;
                mcand  = 33'(r_up[r_k]);
                mplier = r_ver;
            end
            S_MOVE_RGT: begin
                mul_go = 1'b1;
                mcand  = 33'(r_rgt[r_k]);
                mplier = r_lat;
            end
            S_ZOOM: begin
                mul_go = 1'b1;
                mcand  = 33'(r_fwd[r_k]);
                mplier = r_opa;
            end
            S_ROW_MUL: begin
                mul_go = 1'b1;
                mcand  = 33'(row_vec[r_k]);
                mplier = r_pos[r_k];
            end
            default: begin
                mul_go = 1'b0;
            end
        endcase
        mul_go  = mul_go && !r_issued;
        div_go  = div_go && !r_issued;
        sqrt_go = sqrt_go && !r_issued;
        trig_go = trig_go && !r_issued;
    end

    ypc_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_go),
        .i_mcand   (mcand),
        .i_mplier  (mplier),
        .o_done    (mul_done),
        .o_product (prod)
    );

    ypc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_go),
        .i_dividend (dvd),
        .i_divisor  (dsr),
        .o_done     (div_done),
        .o_quot     (quot),
        .o_rem      (drem)
    );

    ypc_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_go),
        .i_radicand (radicand),
        .o_done     (sqrt_done),
        .o_root     (root)
    );

    ypc_cordic #(
        .ITERS (TRIG_ITERATIONS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (trig_go),
        .i_angle (trig_angle),
        .o_done  (trig_done),
        .o_sin   (trig_sin),
        .o_cos   (trig_cos)
    );

    // sequencer: each computing state launches one unit, then waits for its done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issued    <= 1'b0;
            r_k         <= '0;
            r_row       <= '0;
            r_pass      <= 1'b0;
            r_degen     <= 1'b0;
            r_kind      <= REQ_MOVE;
            r_move_gain <= MOVE_GAIN_RST;
            r_rot_gain  <= ROTATE_GAIN_RST;
            r_pos[0]    <= '0;
            r_pos[1]    <= '0;
            r_pos[2]    <= '0;
            r_yaw       <= ANG_W'(DEG_QUARTER);
            r_pitch     <= '0;
            r_fwd[0]    <= '0;
            r_fwd[1]    <= '0;
            r_fwd[2]    <= VEC_W'(VEC_ONE);
            r_rgt[0]    <= VEC_W'(-VEC_ONE);
            r_rgt[1]    <= '0;
            r_rgt[2]    <= '0;
            r_up[0]     <= '0;
            r_up[1]     <= VEC_W'(VEC_ONE);
            r_up[2]     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // in the emit state the output register is handled below
            if (r_out_valid && !i_out_stall && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            if ((r_state != S_IDLE) && (r_state != S_NORM_END) && (r_state != S_EMIT)
                && !r_issued) begin
                r_issued <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid) begin
                        case (i_cfg_index)
                            CFG_MOVE_GAIN:   r_move_gain <= i_cfg_data[15:0];
                            CFG_ROTATE_GAIN: r_rot_gain  <= i_cfg_data[15:0];
                            CFG_START_X:     r_pos[0]    <= i_cfg_data;
                            CFG_START_Y:     r_pos[1]    <= i_cfg_data;
                            CFG_START_Z:     r_pos[2]    <= i_cfg_data;
                            default:         r_pass      <= r_pass;
                        endcase
                    end
                    if (in_acc) begin
                        r_kind  <= i_req_type;
                        r_opa   <= i_operand_a;
                        r_opb   <= i_operand_b;
                        r_degen <= 1'b0;
                        r_k     <= '0;
                        r_row   <= ROW_RIGHT;
                        r_acc   <= '0;
                        case (i_req_type)
                            REQ_MOVE:   r_state <= S_GAIN_A;
                            REQ_ROTATE: r_state <= S_GAIN_A;
                            REQ_ZOOM:   r_state <= S_ZOOM;
                            default:    r_state <= S_ROW_MUL;
                        endcase
                    end
                end
                S_GAIN_A: begin
                    if (r_issued && mul_done) begin
                        r_issued <= 1'b0;
                        if (r_kind == REQ_MOVE) begin
                            r_lat   <= p16;
                            r_state <= S_GAIN_B;
                        end else begin
                            r_wsum  <= 34'($signed({1'b0, r_yaw})) + 34'(p16);
                            r_k     <= 2'd0;
                            r_state <= S_WRAP;
                        end
                    end
                end
                S_GAIN_B: begin
                    if (r_issued && mul_done) begin
                        r_issued <= 1'b0;
                        if (r_kind == REQ_MOVE) begin
                            r_ver   <= p16;
                            r_k     <= 2'd0;
                            r_state <= S_MOVE_UP;
                        end else begin
                            r_wsum  <= 34'($signed({1'b0, r_pitch})) + 34'(p16);
                            r_k     <= 2'd1;
                            r_state <= S_WRAP;
                        end
                    end
                end
                S_WRAP: begin
                    // angle modulo 360 degrees via the divider remainder
                    if (r_issued && div_done) begin
                        r_issued <= 1'b0;
                        if (r_k == 2'd0) begin
                            r_yaw   <= wrapped;
                            r_state <= S_GAIN_B;
                        end else begin
                            r_pitch <= wrapped;
                            r_k     <= 2'd0;
                            r_state <= S_TRIG;
                        end
                    end
                end
                S_TRIG: begin
                    if (r_issued && trig_done) begin
                        r_issued <= 1'b0;
                        if (r_k == 2'd0) begin
                            r_sy <= trig_sin;
                            r_cy <= trig_cos;
                            r_k  <= 2'd1;
                        end else begin
                            r_sp    <= trig_sin;
                            r_cp    <= trig_cos;
                            r_k     <= 2'd0;
                            r_state <= S_FWD;
                        end
                    end
                end
                S_FWD: begin
                    if (r_issued && mul_done) begin
                        r_issued <= 1'b0;
                        if (r_k == 2'd0) begin
                            r_nf[0] <= clamp_vec((prod + (64'sd1 <<< (FWD_SHIFT - 1)))
                                                 >>> FWD_SHIFT);
                            r_k     <= 2'd1;
                        end else begin
                            r_nf[1] <= clamp_vec(sq_val);
                            r_nf[2] <= clamp_vec((prod + (64'sd1 <<< (FWD_SHIFT - 1)))
                                                 >>> FWD_SHIFT);
                            // right before normalising is forward x world up
                            r_nv[0] <= -18'(clamp_vec((prod + (64'sd1 <<< (FWD_SHIFT - 1)))
                                                      >>> FWD_SHIFT));
                            r_nv[1] <= '0;
                            r_nv[2] <= 18'(r_nf[0]);
                            r_acc   <= '0;
                            r_pass  <= 1'b0;
                            r_k     <= 2'd0;
                            r_state <= S_SQ;
                        end
                    end
                end
                S_SQ: begin
                    if (r_issued && mul_done) begin
                        r_issued <= 1'b0;
                        r_acc    <= r_acc + prod;
                        if (r_k == 2'd2) begin
                            r_state <= S_SQRT;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                S_SQRT: begin
                    if (r_issued && sqrt_done) begin
                        r_issued <= 1'b0;
                        if (root == 32'd0) begin
                            // forward along world up: keep old right and up
                            r_degen <= 1'b1;
                            r_fwd   <= r_nf;
                            r_row   <= ROW_RIGHT;
                            r_k     <= 2'd0;
                            r_acc   <= '0;
                            r_state <= S_ROW_MUL;
                        end else begin
                            r_len   <= root;
                            r_k     <= 2'd0;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (r_issued && div_done) begin
                        r_issued  <= 1'b0;
                        r_no[r_k] <= clamp_vec(qsigned);
                        if (r_k == 2'd2) begin
                            r_state <= S_NORM_END;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                S_NORM_END: begin
                    if (!r_pass) begin
                        r_nr    <= r_no;
                        r_k     <= 2'd0;
                        r_acc   <= '0;
                        r_state <= S_CROSS;
                    end else begin
                        r_fwd   <= r_nf;
                        r_rgt   <= r_nr;
                        r_up    <= r_no;
                        r_row   <= ROW_RIGHT;
                        r_k     <= 2'd0;
                        r_acc   <= '0;
                        r_state <= S_ROW_MUL;
                    end
                end
                S_CROSS: begin
                    // up before normalising is right x forward
                    if (r_issued && mul_done) begin
                        r_issued <= 1'b0;
                        case (r_k)
                            2'd0: r_nv[0] <= 18'(((-prod) + 64'sd8192) >>> VEC_FRAC);
                            2'd1: r_acc   <= prod;
                            2'd2: r_nv[1] <= 18'(((r_acc - prod) + 64'sd8192) >>> VEC_FRAC);
                            default: r_nv[2] <= 18'(p14);
                        endcase
                        if (r_k == 2'd3) begin
                            r_acc   <= '0;
                            r_pass  <= 1'b1;
                            r_k     <= 2'd0;
                            r_state <= S_SQ;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                S_MOVE_UP: begin
                    if (r_issued && mul_done) begin
                        r_issued <= 1'b0;
                        r_t1     <= 36'(p14);
                        r_state  <= S_MOVE_RGT;
                    end
                end
                S_MOVE_RGT: begin
                    if (r_issued && mul_done) begin
                        r_issued   <= 1'b0;
                        r_pos[r_k] <= sat32(64'(r_pos[r_k]) + 64'(r_t1) + p14);
                        if (r_k == 2'd2) begin
                            r_row   <= ROW_RIGHT;
                            r_k     <= 2'd0;
                            r_acc   <= '0;
                            r_state <= S_ROW_MUL;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_MOVE_UP;
                        end
                    end
                end
                S_ZOOM: begin
                    if (r_issued && mul_done) begin
                        r_issued   <= 1'b0;
                        r_pos[r_k] <= sat32(64'(r_pos[r_k]) + p14);
                        if (r_k == 2'd2) begin
                            r_row   <= ROW_RIGHT;
                            r_k     <= 2'd0;
                            r_acc   <= '0;
                            r_state <= S_ROW_MUL;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                S_ROW_MUL: begin
                    // dot product of the row with position
                    if (r_issued && mul_done) begin
                        r_issued <= 1'b0;
                        r_acc    <= r_acc + prod;
                        if (r_k == 2'd2) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_row   <= r_row;
                        r_out_cx    <= row_vec[0];
                        r_out_cy    <= row_vec[1];
                        r_out_cz    <= row_vec[2];
                        r_out_trans <= sat32(-((r_acc + 64'sd8192) >>> VEC_FRAC));
                        r_out_degen <= r_degen;
                        r_out_last  <= (r_row == ROW_FWD);
                        if (r_row == ROW_FWD) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_row   <= r_row + 1'b1;
                            r_k     <= 2'd0;
                            r_acc   <= '0;
                            r_state <= S_ROW_MUL;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_row_index   = r_out_row;
    assign o_coef_x      = r_out_cx;
    assign o_coef_y      = r_out_cy;
    assign o_coef_z      = r_out_cz;
    assign o_translation = r_out_trans;
    assign o_degenerate  = r_out_degen;
    assign o_last        = r_out_last;

endmodule

// ----- rtl/ypc_mul.sv -----
// bit-serial signed multiplier, one multiplier bit per cycle
// depends on ypc_pkg
`timescale 1ns / 1ps

module ypc_mul import ypc_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic signed [MUL_BITS:0]   i_mcand,
    input  logic signed [MUL_BITS-1:0] i_mplier,
    output logic                       o_done,
    output logic signed [63:0]         o_product
);

    localparam int CNT_W = $clog2(MUL_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MUL_BITS - 1);

    logic signed [MUL_BITS:0]   r_mcand;
    logic signed [MUL_BITS+1:0] r_hi;
    logic [MUL_BITS-1:0]        r_lo;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic signed [MUL_BITS+1:0] n_hi;

    // sign bit of the multiplier has negative weight
    always_comb begin
        n_hi = r_hi;
        if (r_lo[0]) begin
            if (r_cnt == CNT_LAST) begin
                n_hi = r_hi - (MUL_BITS+2)'(r_mcand);
            end else begin
                n_hi = r_hi + (MUL_BITS+2)'(r_mcand);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_mcand <= i_mcand;
                r_hi    <= '0;
                r_lo    <= i_mplier;
                r_cnt   <= '0;
                r_busy  <= 1'b1;
            end else if (r_busy) begin
                r_hi  <= {n_hi[MUL_BITS+1], n_hi[MUL_BITS+1:1]};
                r_lo  <= {n_hi[0], r_lo[MUL_BITS-1:1]};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done    = r_done;
    assign o_product = {r_hi[63-MUL_BITS:0], r_lo};

endmodule

// ----- rtl/ypc_div.sv -----
// restoring unsigned divider, one quotient bit per cycle
// depends on ypc_pkg
`timescale 1ns / 1ps

module ypc_div import ypc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [DIV_BITS-1:0] i_dividend,
    input  logic [31:0]         i_divisor,
    output logic                o_done,
    output logic [DIV_BITS-1:0] o_quot,
    output logic [31:0]         o_rem
);

    localparam int CNT_W = $clog2(DIV_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_BITS - 1);

    logic [DIV_BITS-1:0] r_q;
    logic [31:0]         r_rem;
    logic [31:0]         r_den;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [32:0]         n_sh;
    logic                n_ge;
    logic [32:0]         n_diff;

    always_comb begin
        n_sh   = {r_rem, r_q[DIV_BITS-1]};
        n_ge   = n_sh >= {1'b0, r_den};
        n_diff = n_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q    <= i_dividend;
                r_rem  <= '0;
                r_den  <= i_divisor;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= n_ge ? n_diff[31:0] : n_sh[31:0];
                r_q   <= {r_q[DIV_BITS-2:0], n_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

endmodule

// ----- rtl/ypc_sqrt.sv -----
// digit-by-digit integer square root (floor), two radicand bits per cycle
// depends on ypc_pkg
`timescale 1ns / 1ps

module ypc_sqrt import ypc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_radicand,
    output logic        o_done,
    output logic [31:0] o_root
);

    localparam int CNT_W = $clog2(SQRT_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SQRT_STEPS - 1);

    logic [63:0]      r_n;
    logic [33:0]      r_rem;
    logic [31:0]      r_root;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [35:0]      n_sh;
    logic [35:0]      n_trial;
    logic             n_ge;
    logic [35:0]      n_diff;

    always_comb begin
        n_sh    = {r_rem, r_n[63:62]};
        n_trial = {2'b00, r_root, 2'b01};
        n_ge    = n_sh >= n_trial;
        n_diff  = n_sh - n_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_n    <= i_radicand;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= n_ge ? n_diff[33:0] : n_sh[33:0];
                r_root <= {r_root[30:0], n_ge};
                r_n    <= {r_n[61:0], 2'b00};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ----- rtl/ypc_cordic.sv -----
// iterative rotation-mode cordic, sine and cosine of a degree angle
// one micro-rotation per cycle; depends on ypc_pkg
`timescale 1ns / 1ps

module ypc_cordic import ypc_pkg::*; #(
    parameter int ITERS = TRIG_ITERATIONS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [ANG_W-1:0]   i_angle,
    output logic               o_done,
    output logic signed [31:0] o_sin,
    output logic signed [31:0] o_cos
);

    localparam logic [4:0] CNT_LAST = 5'(ITERS - 1);

    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [25:0] r_z;
    logic               r_neg;
    logic [4:0]         r_cnt;
    logic               r_busy;
    logic               r_done;
    logic signed [25:0] n_a;
    logic signed [25:0] n_z0;
    logic               n_neg0;
    logic signed [31:0] n_dx;
    logic signed [31:0] n_dy;
    logic signed [25:0] n_at;

    // fold the angle into [-90, 90] degrees
    always_comb begin
        n_a = $signed({1'b0, i_angle});
        if (i_angle >= ANG_W'(DEG_HALF)) begin
            n_a = 26'(n_a - DEG_FULL);
        end
        n_neg0 = 1'b0;
        n_z0   = n_a;
        if (n_a > 26'sd5898240) begin
            n_z0   = 26'(n_a - DEG_HALF);
            n_neg0 = 1'b1;
        end else if (n_a < -26'sd5898240) begin
            n_z0   = 26'(n_a + DEG_HALF);
            n_neg0 = 1'b1;
        end
        n_dx = r_y >>> r_cnt;
        n_dy = r_x >>> r_cnt;
        n_at = $signed({3'b000, ypc_atan(r_cnt)});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_x    <= CORDIC_K;
                r_y    <= '0;
                r_z    <= n_z0;
                r_neg  <= n_neg0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (!r_z[25]) begin
                    r_x <= r_x - n_dx;
                    r_y <= r_y + n_dy;
                    r_z <= r_z - n_at;
                end else begin
                    r_x <= r_x + n_dx;
                    r_y <= r_y - n_dy;
                    r_z <= r_z + n_at;
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_neg ? -r_x : r_x;
    assign o_sin  = r_neg ? -r_y : r_y;

endmodule

// ----- test/yaw_pitch_camera_view_update_tb.sv -----
// self-checking bench for the camera view block: directed steps, then random events
// depends on ypc_pkg and yaw_pitch_camera_view_update
`timescale 1ns / 1ps

module yaw_pitch_camera_view_update_tb;
    import ypc_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 30000;
    localparam longint FULL_TURN = 64'sd360 * 65536;
    localparam longint HALF_TURN = 64'sd180 * 65536;
    localparam longint QUARTER_TURN = 64'sd90 * 65536;
    localparam longint UNIT = 64'sd1 << VEC_FRAC;

    typedef longint vec3_t [3];

    // one expected matrix row
    typedef struct {
        logic [1:0]         row;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic signed [15:0] cz;
        logic signed [31:0] tr;
        logic               degen;
        logic               last;
    } row_beat_t;

    // one step of the directed table: a settings write or an event
    typedef struct {
        bit          is_cfg;
        logic [2:0]  idx;
        logic [1:0]  req;
        logic [31:0] a;
        logic [31:0] b;
        bit          known;
        int          kx;
        int          ky;
        int          kz;
        int          ktr;
    } step_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_req_type = '0;
    logic signed [31:0] i_operand_a = '0;
    logic signed [31:0] i_operand_b = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [1:0]         o_row_index;
    logic signed [15:0] o_coef_x;
    logic signed [15:0] o_coef_y;
    logic signed [15:0] o_coef_z;
    logic signed [31:0] o_translation;
    logic               o_degenerate;
    logic               o_last;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = '0;
    logic [31:0]        i_cfg_data = '0;

    yaw_pitch_camera_view_update i_dut (.*);

    // camera state as the bench sees it
    longint    cam_pos [3];
    longint    yaw_deg;
    longint    pitch_deg;
    vec3_t     fwd;
    vec3_t     rgt;
    vec3_t     upv;
    longint    move_k;
    longint    turn_k;
    row_beat_t rows_due [$];
    int        fails = 0;
    bit        quiet = 1'b0;
    int        idle_cycles = 0;

    // arctangent of 2^-i, degrees Q16.16
    const longint arc_tab [16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                                   58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                                   229, 115};

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // round half up then arithmetic shift
    function automatic longint rshr(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint clip_unit(input longint v);
        if (v > UNIT) return UNIT;
        if (v < -UNIT) return -UNIT;
        return v;
    endfunction

    // divide rounding half away from zero
    function automatic longint div_away(input longint num, input longint den);
        longint m;
        longint q;
        m = (num < 0) ? -num : num;
        q = (m + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint unsigned root_floor(input longint unsigned n);
        longint unsigned r;
        longint unsigned bit_w;
        r = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > n) bit_w = bit_w >> 2;
        while (bit_w != 0) begin
            if (n >= r + bit_w) begin
                n = n - (r + bit_w);
                r = (r >> 1) + bit_w;
            end else begin
                r = r >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return r;
    endfunction

    // sine and cosine in Q1.30 of an angle in [0, 360) degrees
    task automatic cordic_deg(input longint ang, output longint s, output longint c);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        bit     flip;
        x = longint'(CORDIC_K);
        y = 0;
        flip = 1'b0;
        if (ang >= HALF_TURN) ang = ang - FULL_TURN;
        if (ang > QUARTER_TURN) begin
            ang = ang - HALF_TURN;
            flip = 1'b1;
        end else if (ang < -QUARTER_TURN) begin
            ang = ang + HALF_TURN;
            flip = 1'b1;
        end
        z = ang;
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - arc_tab[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + arc_tab[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    // unit length; zero length reports failure
    function automatic bit unit_len(input vec3_t v, output vec3_t o);
        longint unsigned sq;
        longint unsigned len;
        sq = 0;
        for (int i = 0; i < 3; i++) sq = sq + longint'(v[i] * v[i]);
        len = root_floor(sq << (58 - 2 * VEC_FRAC));
        if (len == 0) return 1'b0;
        for (int i = 0; i < 3; i++) o[i] = clip_unit(div_away(v[i] <<< 29, longint'(len)));
        return 1'b1;
    endfunction

    function automatic longint wrap_turn(input longint a);
        longint r;
        r = a % FULL_TURN;
        return (r < 0) ? r + FULL_TURN : r;
    endfunction

    // rebuild the basis from yaw and pitch; false keeps old right and up
    task automatic rebuild_basis(output bit ok);
        longint sy;
        longint cy;
        longint sp;
        longint cp;
        vec3_t  rv;
        vec3_t  r;
        vec3_t  uv;
        vec3_t  u;
        cordic_deg(yaw_deg, sy, cy);
        cordic_deg(pitch_deg, sp, cp);
        fwd[0] = clip_unit(rshr(cy * cp, 60 - VEC_FRAC));
        fwd[1] = clip_unit(rshr(sp, 30 - VEC_FRAC));
        fwd[2] = clip_unit(rshr(sy * cp, 60 - VEC_FRAC));
        rv = '{-fwd[2], 0, fwd[0]};
        ok = 1'b0;
        if (!unit_len(rv, r)) return;
        uv[0] = rshr(-r[2] * fwd[1], VEC_FRAC);
        uv[1] = rshr(r[2] * fwd[0] - r[0] * fwd[2], VEC_FRAC);
        uv[2] = rshr(r[0] * fwd[1], VEC_FRAC);
        if (!unit_len(uv, u)) return;
        rgt = r;
        upv = u;
        ok = 1'b1;
    endtask

    task automatic reset_camera();
        move_k = MOVE_GAIN_RST;
        turn_k = ROTATE_GAIN_RST;
        cam_pos = '{0, 0, 0};
        yaw_deg = QUARTER_TURN;
        pitch_deg = 0;
        fwd = '{0, 0, UNIT};
        rgt = '{-UNIT, 0, 0};
        upv = '{0, UNIT, 0};
    endtask

    // apply one event and queue the three view rows it produces
    task automatic predict_view(input logic [1:0] req, input logic [31:0] a_raw,
                                input logic [31:0] b_raw);
        longint    a;
        longint    b;
        longint    lat;
        longint    ver;
        longint    acc;
        vec3_t     row;
        bit        ok;
        bit        degen;
        row_beat_t beat;
        a = longint'($signed(a_raw));
        b = longint'($signed(b_raw));
        degen = 1'b0;
        case (req)
            REQ_MOVE: begin
                lat = rshr(a * move_k, 16);
                ver = rshr(b * move_k, 16);
                for (int i = 0; i < 3; i++)
                    cam_pos[i] = clip32(cam_pos[i] + rshr(upv[i] * ver, VEC_FRAC)
                                        + rshr(rgt[i] * lat, VEC_FRAC));
            end
            REQ_ROTATE: begin
                yaw_deg = wrap_turn(yaw_deg + rshr(a * turn_k, 16));
                pitch_deg = wrap_turn(pitch_deg + rshr(b * turn_k, 16));
                rebuild_basis(ok);
                degen = !ok;
            end
            REQ_ZOOM: begin
                for (int i = 0; i < 3; i++)
                    cam_pos[i] = clip32(cam_pos[i] + rshr(fwd[i] * a, VEC_FRAC));
            end
            default: ;
        endcase
        for (int k = 0; k < 3; k++) begin
            acc = 0;
            for (int i = 0; i < 3; i++) begin
                row[i] = (k == ROW_RIGHT) ? rgt[i] : (k == ROW_UP) ? upv[i] : -fwd[i];
                acc = acc + row[i] * cam_pos[i];
            end
            beat.row = 2'(k);
            beat.cx = 16'(row[0]);
            beat.cy = 16'(row[1]);
            beat.cz = 16'(row[2]);
            beat.tr = 32'(clip32(-rshr(acc, VEC_FRAC)));
            beat.degen = degen;
            beat.last = (k == ROW_FWD);
            rows_due.push_back(beat);
        end
    endtask

    // one event beat; valid is left high for a back-to-back follower
    task automatic send_event(input logic [1:0] req, input logic [31:0] a,
                              input logic [31:0] b);
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_operand_a <= a;
        i_operand_b <= b;
        do @(posedge i_clk); while (o_in_stall);
        predict_view(req, a, b);
    endtask

    // settings write, only once every row has drained
    task automatic write_setting(input logic [2:0] idx, input logic [31:0] data);
        i_in_valid <= 1'b0;
        wait (rows_due.size() == 0);
        repeat (6) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_MOVE_GAIN:   move_k = data[15:0];
            CFG_ROTATE_GAIN: turn_k = data[15:0];
            CFG_START_X:     cam_pos[0] = longint'($signed(data));
            CFG_START_Y:     cam_pos[1] = longint'($signed(data));
            CFG_START_Z:     cam_pos[2] = longint'($signed(data));
            default: ;
        endcase
    endtask

    // random input gap, none in the quiet tail
    task automatic maybe_gap();
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return 32'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
            2:       return ($urandom_range(0, 1) == 1) ? 32'h7FFFFFFF : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 2 ** 25)) - 2 ** 24);
        endcase
    endfunction

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(0, 4))
            0:       return 32'd0;
            1:       return 32'd65535;
            default: return {16'($urandom), 16'($urandom)};
        endcase
    endfunction

    // output side: bursts of stall, dropped in the quiet tail
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (quiet) begin
            i_out_stall <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_stall <= (stall_left > 1);
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(1, 19);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // compare each row beat with the oldest expectation
    always @(posedge i_clk) begin
        row_beat_t due;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (rows_due.size() == 0) begin
                $display("%0t: row beat %0d with nothing expected", $time, o_row_index);
                fails++;
            end else begin
                due = rows_due.pop_front();
                if (o_row_index !== due.row) begin
                    $display("%0t: row_index expected %0d got %0d", $time, due.row,
                             o_row_index);
                    fails++;
                end
                if (o_coef_x !== due.cx) begin
                    $display("%0t: coef_x expected %0d got %0d", $time, due.cx, o_coef_x);
                    fails++;
                end
                if (o_coef_y !== due.cy) begin
                    $display("%0t: coef_y expected %0d got %0d", $time, due.cy, o_coef_y);
                    fails++;
                end
                if (o_coef_z !== due.cz) begin
                    $display("%0t: coef_z expected %0d got %0d", $time, due.cz, o_coef_z);
                    fails++;
                end
                if (o_translation !== due.tr) begin
                    $display("%0t: translation expected %0d got %0d", $time, due.tr,
                             o_translation);
                    fails++;
                end
                if (o_degenerate !== due.degen) begin
                    $display("%0t: degenerate expected %0b got %0b", $time, due.degen,
                             o_degenerate);
                    fails++;
                end
                if (o_last !== due.last) begin
                    $display("%0t: last expected %0b got %0b", $time, due.last, o_last);
                    fails++;
                end
            end
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // directed steps: unknown kind, zero moves and zooms after reset give the
    // reset basis with zero translation; pitch steps of 90 degrees cross the
    // vertical twice (degenerate), then wrap; settings and operands at extremes
    step_t plan [] = '{
        '{1'b0, 3'd0, REQ_UNUSED, 32'd0, 32'd0, 1'b1, -16384, 0, 0, 0},
        '{1'b0, 3'd0, REQ_MOVE, 32'd0, 32'd0, 1'b1, -16384, 0, 0, 0},
        '{1'b0, 3'd0, REQ_ZOOM, 32'd0, 32'hFFFFFFFF, 1'b1, -16384, 0, 0, 0},
        '{1'b0, 3'd0, REQ_MOVE, 32'h7FFFFFFF, 32'h80000000, 1'b0, 0, 0, 0, 0},
        '{1'b0, 3'd0, REQ_ZOOM, 32'h7FFFFFFF, 32'd0, 1'b0, 0, 0, 0, 0},
        '{1'b1, CFG_ROTATE_GAIN, 2'd0, 32'd32768, 32'd0, 1'b0, 0, 0, 0, 0},
        '{1'b0, 3'd0, REQ_ROTATE, 32'd0, 32'd11796480, 1'b0, 0, 0, 0, 0},
        '{1'b0, 3'd0, REQ_MOVE, 32'd1000000, 32'd2000000, 1'b0, 0, 0, 0, 0},
        '{1'b0, 3'd0, REQ_ROTATE, 32'd0, 32'd11796480, 1'b0, 0, 0, 0, 0},
        '{1'b0, 3'd0, REQ_ROTATE, 32'd0, 32'd11796480, 1'b0, 0, 0, 0, 0},
        '{1'b0, 3'd0, REQ_ROTATE, 32'd0, 32'd11796480, 1'b0, 0, 0, 0, 0},
        '{1'b1, CFG_MOVE_GAIN, 2'd0, 32'hFFFFFFFF, 32'd0, 1'b0, 0, 0, 0, 0},
        '{1'b1, CFG_START_X, 2'd0, 32'h7FFFFFFF, 32'd0, 1'b0, 0, 0, 0, 0},
        '{1'b1, CFG_START_Y, 2'd0, 32'h80000000, 32'd0, 1'b0, 0, 0, 0, 0},
        '{1'b1, CFG_START_Z, 2'd0, 32'h12345678, 32'd0, 1'b0, 0, 0, 0, 0},
        '{1'b0, 3'd0, REQ_UNUSED, 32'h55555555, 32'hAAAAAAAA, 1'b0, 0, 0, 0, 0},
        '{1'b0, 3'd0, REQ_MOVE, 32'h80000000, 32'h7FFFFFFF, 1'b0, 0, 0, 0, 0},
        '{1'b0, 3'd0, REQ_MOVE, 32'h7FFFFFFF, 32'h80000000, 1'b0, 0, 0, 0, 0},
        '{1'b0, 3'd0, REQ_ZOOM, 32'h80000000, 32'd0, 1'b0, 0, 0, 0, 0},
        '{1'b0, 3'd0, REQ_ROTATE, 32'h7FFFFFFF, 32'h80000000, 1'b0, 0, 0, 0, 0},
        '{1'b1, CFG_MOVE_GAIN, 2'd0, 32'd0, 32'd0, 1'b0, 0, 0, 0, 0},
        '{1'b1, CFG_ROTATE_GAIN, 2'd0, 32'hFFFF, 32'd0, 1'b0, 0, 0, 0, 0},
        '{1'b0, 3'd0, REQ_MOVE, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0, 0, 0, 0, 0},
        '{1'b0, 3'd0, REQ_ROTATE, 32'h80000000, 32'h7FFFFFFF, 1'b0, 0, 0, 0, 0},
        '{1'b0, 3'd0, REQ_ZOOM, 32'hFFFFFFFF, 32'd0, 1'b0, 0, 0, 0, 0}
    };

    initial begin
        logic [1:0] req;
        int         n;
        reset_camera();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[s]) begin
            if (plan[s].is_cfg) begin
                write_setting(plan[s].idx, plan[s].a);
            end else begin
                send_event(plan[s].req, plan[s].a, plan[s].b);
                if (plan[s].known) begin
                    // right row typed in directly
                    n = rows_due.size() - 3;
                    rows_due[n].cx = 16'(plan[s].kx);
                    rows_due[n].cy = 16'(plan[s].ky);
                    rows_due[n].cz = 16'(plan[s].kz);
                    rows_due[n].tr = 32'(plan[s].ktr);
                end
                maybe_gap();
            end
        end

        // random part in phases, each with new settings
        for (int item = 0; item < 111; item++) begin
            if (item % 26 == 0) begin
                write_setting(CFG_MOVE_GAIN, pick_gain());
                write_setting(CFG_ROTATE_GAIN, pick_gain());
                write_setting(CFG_START_X, pick_operand());
                write_setting(CFG_START_Y, pick_operand());
                write_setting(CFG_START_Z, pick_operand());
            end
            if (item == 60) begin
                // hold off until the matrix has fully drained
                i_in_valid <= 1'b0;
                wait (rows_due.size() == 0);
            end
            if (item == 90) quiet = 1'b1;
            case ($urandom_range(0, 9))
                0, 1, 2: req = REQ_MOVE;
                3, 4, 5: req = REQ_ROTATE;
                6, 7, 8: req = REQ_ZOOM;
                default: req = REQ_UNUSED;
            endcase
            send_event(req, pick_operand(), pick_operand());
            maybe_gap();
        end
        i_in_valid <= 1'b0;

        wait (rows_due.size() == 0);
        repeat (50) @(posedge i_clk);
        if (fails == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
